@@ sv/bdq_pkg.sv @@
// Shared types, codes and constants for the bounded deque with value removal.
package bdq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic exec;
    logic scan_init;
    logic scan_run;
    logic finish;
  } dq_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic scan_done;
  } dq_sts_t;

endpackage

@@ sv/bdq_ctrl.sv @@
// Controller state machine that sequences requests and the removal scan.
module bdq_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [bdq_pkg::FUNC_W-1:0] in_func,
  input  bdq_pkg::dq_sts_t        sts,
  output bdq_pkg::dq_cmd_t        cmd,
  output logic                    busy,
  output logic                    out_valid
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == FN_REMOVE && !sts.occ_zero) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            cmd.exec      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r == S_SCAN);
  assign out_valid = out_valid_r;

endmodule

@@ sv/bdq_dp.sv @@
// Datapath with the circular entry memory, pointers, scan counters and result registers.
module bdq_dp #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bdq_pkg::dq_cmd_t                cmd,
  input  logic [bdq_pkg::FUNC_W-1:0]      in_func,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  output bdq_pkg::dq_sts_t                sts,
  output logic [bdq_pkg::STATUS_W-1:0]    out_status,
  output logic [CW-1:0]                   out_count,
  output logic                            out_is_empty,
  output logic [CW-1:0]                   out_removed
);
  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [SW-1:0] WRAP = SW'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] rd_off_r, rd_off_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [DATA_W-1:0]   key_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [CW-1:0]       removed_r, removed_nxt;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= WRAP) begin
      sum = sum - WRAP;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    front_nxt   = front_r;
    occ_nxt     = occ_r;
    rd_off_nxt  = rd_off_r;
    kept_nxt    = kept_r;
    rd_vld_nxt  = rd_vld_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = '0;
    raddr       = '0;
    wdata       = in_value;

    if (cmd.exec) begin
      status_nxt  = ST_OK;
      removed_nxt = '0;
      case (in_func)
        FN_PUSH_FRONT: begin
          if (occ_r == FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            front_nxt = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
            we        = 1'b1;
            waddr     = front_nxt;
            occ_nxt   = occ_r + CW'(1);
          end
        end
        FN_PUSH_BACK: begin
          if (occ_r == FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = slot_of(front_r, occ_r);
            occ_nxt = occ_r + CW'(1);
          end
        end
        FN_POP_FRONT: begin
          if (occ_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            front_nxt = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);
            occ_nxt   = occ_r - CW'(1);
          end
        end
        FN_POP_BACK: begin
          if (occ_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            occ_nxt = occ_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.scan_init) begin
      rd_off_nxt = '0;
      kept_nxt   = '0;
      rd_vld_nxt = 1'b0;
    end

    if (cmd.scan_run) begin
      if (rd_off_r < occ_r) begin
        re         = 1'b1;
        raddr      = slot_of(front_r, rd_off_r);
        rd_off_nxt = rd_off_r + CW'(1);
        rd_vld_nxt = 1'b1;
      end else begin
        rd_vld_nxt = 1'b0;
      end
      if (rd_vld_r && mem_q_r != key_r) begin
        we       = 1'b1;
        waddr    = slot_of(front_r, kept_r);
        wdata    = mem_q_r;
        kept_nxt = kept_r + CW'(1);
      end
    end

    if (cmd.finish) begin
      occ_nxt     = kept_r;
      removed_nxt = occ_r - kept_r;
      status_nxt  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      occ_r    <= '0;
      rd_off_r <= '0;
      kept_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      front_r  <= front_nxt;
      occ_r    <= occ_nxt;
      rd_off_r <= rd_off_nxt;
      kept_r   <= kept_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    if (cmd.scan_init) begin
      key_r <= in_value;
    end
  end

  assign sts.occ_zero  = (occ_r == '0);
  assign sts.scan_done = (rd_off_r == occ_r) && !rd_vld_r;

  assign out_status   = status_r;
  assign out_count    = occ_r;
  assign out_is_empty = (occ_r == '0);
  assign out_removed  = removed_r;

endmodule

@@ sv/bounded_deque_with_value_removal.sv @@
// Top level of the bounded deque of signed values with in-order value removal.
// Push, pop, unused and empty-deque remove requests: the result strobes in the cycle after
// the request is taken, and busy stays low, so such a request can be taken every cycle.
// Remove value on a nonempty deque: busy while one memory read port scans every entry
// and one write port compacts the survivors; the result follows.
// Synchronous active-low reset empties the deque; the entry memory itself is not cleared.
module bounded_deque_with_value_removal #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bdq_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic [bdq_pkg::STATUS_W-1:0]      out_status,
  output logic [CW-1:0]                     out_count,
  output logic                              out_is_empty,
  output logic [CW-1:0]                     out_removed
);
  import bdq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bdq_dp #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_value     (in_value),
    .sts          (sts),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .out_removed  (out_removed)
  );

endmodule

@@ sv/bdq_checker.sv @@
// Port-level checker for the bounded deque and the bind that attaches it.
module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [bdq_pkg::FUNC_W-1:0]   in_func,
  input logic                         out_valid,
  input logic [bdq_pkg::STATUS_W-1:0] out_status,
  input logic [CW-1:0]                out_count,
  input logic                         out_is_empty,
  input logic [CW-1:0]                out_removed
);
  import bdq_pkg::*;

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  a_simple_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func != FN_REMOVE |=> out_valid)
    else $error("A push or pop request produced no result in the next cycle.");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (out_count == '0))
    else $error("The empty flag disagrees with the entry count.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= FULL_CNT && out_removed <= FULL_CNT)
    else $error("A result reports more entries than the deque holds.");

  a_no_removal_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_removed == '0)
    else $error("A rejected request reports removed entries.");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy ##1 !busy |-> out_valid)
    else $error("A removal scan ended without a result.");

endmodule

bind bounded_deque_with_value_removal bdq_checker #(
  .DEPTH (DEPTH),
  .CW    (CW)
) u_bdq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_func      (in_func),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_count    (out_count),
  .out_is_empty (out_is_empty),
  .out_removed  (out_removed)
);
